/* rtl/ifla_pkg.sv */
`timescale 1ns / 1ps

package ifla_pkg;

	// Number of indices the allocator can hand out
	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;

	// Operation codes on func
	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_STATUS  = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	// Link value that marks the end of the free list
	localparam logic [CNT_W-1:0] LINK_END = CNT_W'(CAPACITY);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

/* rtl/ifla_ram.sv */
`timescale 1ns / 1ps

module ifla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/index_free_list_allocator.sv */
`timescale 1ns / 1ps
// Each item is read, then updated: on acceptance it is captured and the link and taken-flag
// memories are read synchronously; the head, counters and result are updated in the execute
// state, which waits while an unaccepted result is held. No new item is taken before it ends.
// Reset: asynchronous, active low; free list empty, counters zero, no result held.
// The memories need no clearing: every entry is written before its read value is used.

module index_free_list_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [ifla_pkg::IDX_W-1:0] index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ifla_pkg::IDX_W-1:0] given_index,
	output logic [1:0]                 status,
	output logic [ifla_pkg::CNT_W-1:0] in_use,
	output logic [ifla_pkg::CNT_W-1:0] high_water
);

	import ifla_pkg::*;

	state_t state_q, state_d;

	logic             accept;
	logic             exec_go;

	logic [1:0]       func_q;
	logic [IDX_W-1:0] index_q;

	logic [IDX_W-1:0] head_q, head_d;
	logic             head_vld_q, head_vld_d;
	logic [CNT_W-1:0] created_q, created_d;
	logic [CNT_W-1:0] used_q, used_d;

	logic [CNT_W-1:0] link_rd;
	logic             taken_rd;

	logic             link_we;
	logic [IDX_W-1:0] link_waddr;
	logic [CNT_W-1:0] link_wdata;
	logic             taken_we;
	logic [IDX_W-1:0] taken_waddr;
	logic             taken_wdata;

	logic [IDX_W-1:0] given_d;
	logic [1:0]       status_d;

	logic             out_valid_q;
	logic [IDX_W-1:0] given_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] in_use_q;
	logic [CNT_W-1:0] high_water_q;

	// Link store: next free index, or end marker
	ifla_ram #(
		.WIDTH (CNT_W),
		.DEPTH (CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (head_q),
		.rdata (link_rd)
	);

	// Taken flags, one per created index
	ifla_ram #(
		.WIDTH (1),
		.DEPTH (CAPACITY)
	) u_taken_ram (
		.clk   (clk),
		.we    (taken_we),
		.waddr (taken_waddr),
		.wdata (taken_wdata),
		.re    (accept),
		.raddr (index),
		.rdata (taken_rd)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs of the state machine
	always_comb begin
		in_ready = 1'b0;
		exec_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: exec_go  = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				exec_go  = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// Decide the operation from the read data and build the write-backs
	always_comb begin
		head_d      = head_q;
		head_vld_d  = head_vld_q;
		created_d   = created_q;
		used_d      = used_q;
		given_d     = '0;
		status_d    = STAT_OK;
		link_we     = 1'b0;
		link_waddr  = index_q;
		link_wdata  = LINK_END;
		taken_we    = 1'b0;
		taken_waddr = index_q;
		taken_wdata = 1'b0;
		unique case (func_q)
			FUNC_ALLOC: begin
				if (head_vld_q) begin
					// Pop the head of the free list
					given_d     = head_q;
					head_d      = link_rd[IDX_W-1:0];
					head_vld_d  = (link_rd < LINK_END);
					taken_we    = exec_go;
					taken_waddr = head_q;
					taken_wdata = 1'b1;
					used_d      = used_q + CNT_W'(1);
				end else if (created_q != LINK_END) begin
					// Create a fresh entry
					given_d     = created_q[IDX_W-1:0];
					created_d   = created_q + CNT_W'(1);
					taken_we    = exec_go;
					taken_waddr = created_q[IDX_W-1:0];
					taken_wdata = 1'b1;
					used_d      = used_q + CNT_W'(1);
				end else begin
					status_d = STAT_FULL;
				end
			end
			FUNC_RELEASE: begin
				if (({1'b0, index_q} >= created_q) || !taken_rd) begin
					status_d = STAT_BAD;
				end else begin
					// Push the index onto the free list
					link_we     = exec_go;
					link_wdata  = head_vld_q ? {1'b0, head_q} : LINK_END;
					head_d      = index_q;
					head_vld_d  = 1'b1;
					taken_we    = exec_go;
					taken_wdata = 1'b0;
					used_d      = used_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Capture the item on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			index_q <= index;
		end
	end

	// Control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			head_vld_q <= 1'b0;
			created_q  <= '0;
			used_q     <= '0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				head_q     <= head_d;
				head_vld_q <= head_vld_d;
				created_q  <= created_d;
				used_q     <= used_d;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (exec_go) begin
			given_q      <= given_d;
			status_q     <= status_d;
			in_use_q     <= used_d;
			high_water_q <= created_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign given_index = given_q;
	assign status      = status_q;
	assign in_use      = in_use_q;
	assign high_water  = high_water_q;

endmodule
